### rtl/binomial_mod_prime_tables_macros.svh
// Assertion macros shared by the binomial coefficient table block.
`ifndef BINOMIAL_MOD_PRIME_TABLES_MACROS_SVH
`define BINOMIAL_MOD_PRIME_TABLES_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define BMPT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define BMPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bmpt_pkg.sv
// Types and constants of the binomial coefficient table block.
package bmpt_pkg;

  localparam int TableSize = 4096;
  localparam int IdxW      = $clog2(TableSize);
  localparam int ArgW      = 12;
  localparam int CoefW     = 30;

  localparam logic [CoefW-1:0] PrimeMod = CoefW'(1000000007);
  localparam logic [CoefW-1:0] InvExp   = PrimeMod - CoefW'(2);

  // Barrett reduction of a product below the square of the prime.
  localparam int MulW = 2 * CoefW;
  localparam int QW   = CoefW + 1;
  localparam int RemW = CoefW + 2;
  localparam logic [QW-1:0] BarrettMu = QW'((64'd1 << MulW) / 64'(PrimeMod));
  localparam logic [RemW-1:0] OnePrime   = RemW'(PrimeMod);
  localparam logic [RemW-1:0] TwoPrime   = {1'b0, PrimeMod, 1'b0};
  localparam logic [RemW-1:0] ThreePrime = TwoPrime + OnePrime;

  // Pipeline depth of the modular multiplier.
  localparam int MmLat = 5;

  typedef enum logic {
    OP_BUILD = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic {
    ST_OK        = 1'b0,
    ST_NOT_READY = 1'b1
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FACT_STEP,
    S_FACT_WAIT,
    S_POW_STEP,
    S_POW_WAIT,
    S_INV_STEP,
    S_INV_WAIT,
    S_QRY_READ,
    S_QRY_MUL1,
    S_QRY_WAIT1,
    S_QRY_WAIT2,
    S_RESULT
  } state_t;

endpackage

### rtl/bmpt_if.sv
// Request and response channel interfaces of the binomial coefficient table block.
interface bmpt_req_if import bmpt_pkg::*; ();
  logic            valid;
  logic            ready;
  op_t             operation;
  logic [ArgW-1:0] total_count;
  logic [ArgW-1:0] choose_count;

  modport source (output valid, operation, total_count, choose_count, input ready);
  modport sink   (input valid, operation, total_count, choose_count, output ready);
endinterface

interface bmpt_rsp_if import bmpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CoefW-1:0] coefficient;
  status_t          status;

  modport source (output valid, coefficient, status, input ready);
  modport sink   (input valid, coefficient, status, output ready);
endinterface

### rtl/bmpt_mulmod.sv
// Pipelined multiplier modulo the prime, using Barrett reduction.
`include "binomial_mod_prime_tables_macros.svh"

module bmpt_mulmod import bmpt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CoefW-1:0] a,
  input  logic [CoefW-1:0] b,
  output logic             done,
  output logic [CoefW-1:0] result
);

  logic [MmLat-1:0]   v;
  logic [MulW-1:0]    prod;
  logic [2*QW-1:0]    q2;
  logic [QW-1:0]      q3;
  logic [RemW-1:0]    lo2;
  logic [QW+CoefW-1:0] qp_prod;
  logic [RemW-1:0]    qp_lo;
  logic [RemW-1:0]    lo3;
  logic [RemW-1:0]    rem;
  logic [RemW-1:0]    rem_red;
  logic [CoefW-1:0]   res;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[MmLat-2:0], start};
    end
  end

  // The quotient estimate is at most two below the true quotient.
  always_comb begin
    q2      = (2*QW)'(prod[MulW-1 -: QW]) * (2*QW)'(BarrettMu);
    qp_prod = (QW+CoefW)'(q3) * (QW+CoefW)'(PrimeMod);
    if (rem >= TwoPrime) begin
      rem_red = rem - TwoPrime;
    end else if (rem >= OnePrime) begin
      rem_red = rem - OnePrime;
    end else begin
      rem_red = rem;
    end
  end

  always_ff @(posedge clk) begin
    prod  <= MulW'(a) * MulW'(b);
    q3    <= q2[2*QW-1 -: QW];
    lo2   <= prod[RemW-1:0];
    qp_lo <= qp_prod[RemW-1:0];
    lo3   <= lo2;
    rem   <= lo3 - qp_lo;
    res   <= rem_red[CoefW-1:0];
  end

  assign done   = v[MmLat-1];
  assign result = res;

  `BMPT_ASSERT_IMPLIES(a_mm_result_reduced, done, result < PrimeMod, "product not fully reduced")
  `BMPT_ASSERT_IMPLIES(a_mm_rem_bound, v[MmLat-2], rem < ThreePrime, "Barrett remainder out of range")
  `BMPT_ASSERT_IMPLIES(a_mm_latency, done, $past(start, MmLat), "result without a matching start")

endmodule

### rtl/binomial_mod_prime_tables.sv
// Binomial coefficients modulo 1000000007 from factorial and inverse-factorial memories.
// A query response comes from two dependent passes through the five-stage modular multiplier;
// the next request is taken once the response has been loaded into the response register.
// Not-ready and out-of-range queries skip the multiplier and go straight to the result state.
// A build fills factorials upward, inverts the top one by exponentiation, then fills inverses downward.
// Reset clears the control state and the tables-built flag; the memories are not cleared.
`include "binomial_mod_prime_tables_macros.svh"

module binomial_mod_prime_tables import bmpt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bmpt_req_if.sink   req,
  bmpt_rsp_if.source rsp
);

  localparam logic [IdxW-1:0] IdxLast = IdxW'(TableSize - 1);

  state_t           state, state_next;
  logic [IdxW-1:0]  idx, idx_next;
  logic [IdxW:0]    idx_w;
  logic [IdxW:0]    idx_inc;
  logic [CoefW-1:0] run, run_next;
  logic [CoefW-1:0] acc, acc_next;
  logic [CoefW-1:0] base, base_next;
  logic [CoefW-1:0] expo, expo_next;
  logic             sq, sq_next;
  logic [IdxW-1:0]  qn, qn_next;
  logic [IdxW-1:0]  qr, qr_next;
  logic [IdxW-1:0]  qd, qd_next;
  logic [CoefW-1:0] res_coef, res_coef_next;
  status_t          res_status, res_status_next;
  logic             tables_ready, tables_ready_next;
  logic             out_valid;
  logic [CoefW-1:0] out_coef;
  status_t          out_status;
  logic             load_out;
  logic             n_ok;
  logic             mm_wait;

  logic             mm_start;
  logic [CoefW-1:0] mm_a;
  logic [CoefW-1:0] mm_b;
  logic             mm_done;
  logic [CoefW-1:0] mm_result;

  logic             fact_we;
  logic             inv_we;
  logic [CoefW-1:0] wr_data;
  logic [CoefW-1:0] fact_mem [TableSize];
  logic [CoefW-1:0] inv_mem  [TableSize];
  logic [CoefW-1:0] fact_rd;
  logic [CoefW-1:0] inv_rd_r;
  logic [CoefW-1:0] inv_rd_d;

  bmpt_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .done   (mm_done),
    .result (mm_result)
  );

  // Both memories share the write address; the inverse memory has two read ports.
  always_ff @(posedge clk) begin
    if (fact_we) begin
      fact_mem[idx] <= wr_data;
    end
    fact_rd <= fact_mem[qn];
  end

  always_ff @(posedge clk) begin
    if (inv_we) begin
      inv_mem[idx] <= wr_data;
    end
    inv_rd_r <= inv_mem[qr];
    inv_rd_d <= inv_mem[qd];
  end

  assign idx_w   = {1'b0, idx};
  assign idx_inc = idx_w + (IdxW+1)'(1);
  assign n_ok    = 32'(req.total_count) < 32'(TableSize);

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    run_next          = run;
    acc_next          = acc;
    base_next         = base;
    expo_next         = expo;
    sq_next           = sq;
    qn_next           = qn;
    qr_next           = qr;
    qd_next           = qd;
    res_coef_next     = res_coef;
    res_status_next   = res_status;
    tables_ready_next = tables_ready;
    mm_start          = 1'b0;
    mm_a              = run;
    mm_b              = base;
    fact_we           = 1'b0;
    inv_we            = 1'b0;
    wr_data           = run;
    load_out          = 1'b0;
    req.ready         = 1'b0;

    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          priority if (req.operation == OP_BUILD) begin
            idx_next   = '0;
            run_next   = CoefW'(1);
            state_next = S_FACT_STEP;
          end else if (!tables_ready) begin
            res_coef_next   = '0;
            res_status_next = ST_NOT_READY;
            state_next      = S_RESULT;
          end else if (req.choose_count <= req.total_count && n_ok) begin
            qn_next    = IdxW'(req.total_count);
            qr_next    = IdxW'(req.choose_count);
            qd_next    = IdxW'(req.total_count - req.choose_count);
            state_next = S_QRY_READ;
          end else begin
            res_coef_next   = '0;
            res_status_next = ST_OK;
            state_next      = S_RESULT;
          end
        end
      end
      S_FACT_STEP: begin
        fact_we = 1'b1;
        wr_data = run;
        if (idx == IdxLast) begin
          base_next  = run;
          acc_next   = CoefW'(1);
          expo_next  = InvExp;
          sq_next    = 1'b0;
          state_next = S_POW_STEP;
        end else begin
          mm_start   = 1'b1;
          mm_a       = run;
          mm_b       = CoefW'(idx_inc);
          state_next = S_FACT_WAIT;
        end
      end
      S_FACT_WAIT: begin
        if (mm_done) begin
          run_next   = mm_result;
          idx_next   = idx_inc[IdxW-1:0];
          state_next = S_FACT_STEP;
        end
      end
      S_POW_STEP: begin
        // Exponent bits are taken from the least significant end.
        if (expo == '0) begin
          run_next   = acc;
          idx_next   = IdxLast;
          state_next = S_INV_STEP;
        end else if (!sq && !expo[0]) begin
          sq_next = 1'b1;
        end else begin
          mm_start   = 1'b1;
          mm_a       = sq ? base : acc;
          mm_b       = base;
          state_next = S_POW_WAIT;
        end
      end
      S_POW_WAIT: begin
        if (mm_done) begin
          if (sq) begin
            base_next = mm_result;
            expo_next = expo >> 1;
            sq_next   = 1'b0;
          end else begin
            acc_next = mm_result;
            sq_next  = 1'b1;
          end
          state_next = S_POW_STEP;
        end
      end
      S_INV_STEP: begin
        inv_we  = 1'b1;
        wr_data = (idx_w <= (IdxW+1)'(1)) ? CoefW'(1) : run;
        priority if (idx == '0) begin
          tables_ready_next = 1'b1;
          res_coef_next     = '0;
          res_status_next   = ST_OK;
          state_next        = S_RESULT;
        end else if (idx_w <= (IdxW+1)'(2)) begin
          idx_next = idx - IdxW'(1);
        end else begin
          mm_start   = 1'b1;
          mm_a       = run;
          mm_b       = CoefW'(idx);
          state_next = S_INV_WAIT;
        end
      end
      S_INV_WAIT: begin
        if (mm_done) begin
          run_next   = mm_result;
          idx_next   = idx - IdxW'(1);
          state_next = S_INV_STEP;
        end
      end
      S_QRY_READ: begin
        state_next = S_QRY_MUL1;
      end
      S_QRY_MUL1: begin
        mm_start   = 1'b1;
        mm_a       = inv_rd_r;
        mm_b       = inv_rd_d;
        state_next = S_QRY_WAIT1;
      end
      S_QRY_WAIT1: begin
        // The read addresses are held, so the factorial read data is still valid.
        if (mm_done) begin
          mm_start   = 1'b1;
          mm_a       = fact_rd;
          mm_b       = mm_result;
          state_next = S_QRY_WAIT2;
        end
      end
      S_QRY_WAIT2: begin
        if (mm_done) begin
          res_coef_next   = mm_result;
          res_status_next = ST_OK;
          state_next      = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tables_ready <= 1'b0;
    end else begin
      state        <= state_next;
      tables_ready <= tables_ready_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    run        <= run_next;
    acc        <= acc_next;
    base       <= base_next;
    expo       <= expo_next;
    sq         <= sq_next;
    qn         <= qn_next;
    qr         <= qr_next;
    qd         <= qd_next;
    res_coef   <= res_coef_next;
    res_status <= res_status_next;
  end

  // The response register lets a new request in while the last response waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_coef   <= res_coef;
      out_status <= res_status;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.coefficient = out_coef;
  assign rsp.status      = out_status;

  assign mm_wait = state == S_FACT_WAIT || state == S_POW_WAIT || state == S_INV_WAIT ||
                   state == S_QRY_WAIT1 || state == S_QRY_WAIT2;

  `BMPT_ASSERT_IMPLIES(a_ready_fell, $fell(tables_ready), $past(rst), "tables flag lost")
  `BMPT_ASSERT_IMPLIES(a_mm_expected, mm_done, mm_wait, "unexpected multiplier result")
  `BMPT_ASSERT_IMPLIES(a_not_ready_zero, load_out && res_status == ST_NOT_READY, res_coef == '0, "not-ready response with a value")
  `BMPT_ASSERT_NEXT(a_build_sets_ready, state == S_INV_STEP && idx == '0, tables_ready, "build finished without ready flag")

endmodule

### dv/bmpt_checker.sv
// Response checker for the binomial coefficient table block: predicts each response and compares.
module bmpt_checker import bmpt_pkg::*; (
  input  logic clk,
  input  logic rst,
  bmpt_req_if  req,
  bmpt_rsp_if  rsp,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned PrimeWide = 64'(PrimeMod);
  localparam int ReportLimit = 10;
  localparam int LastIdx = TableSize - 1;

  typedef struct packed {
    logic [CoefW-1:0] coefficient;
    status_t          status;
  } binom_rsp_t;

  binom_rsp_t       expected_coef_q[$];
  logic [CoefW-1:0] fact_tab[TableSize];
  logic [CoefW-1:0] inv_fact_tab[TableSize];
  logic             tables_built;
  int               error_count;
  int               pending_count;

  assign mismatches = error_count;
  assign pending    = pending_count;

  function automatic logic [CoefW-1:0] mod_mul(logic [CoefW-1:0] a, logic [CoefW-1:0] b);
    longint unsigned prod;
    prod = longint'(a) * longint'(b);
    return CoefW'(prod % PrimeWide);
  endfunction

  function automatic logic [CoefW-1:0] mod_pow(logic [CoefW-1:0] base, logic [CoefW-1:0] expo);
    logic [CoefW-1:0] acc;
    logic [CoefW-1:0] sq;
    acc = CoefW'(1);
    sq  = base;
    for (int k = 0; k < CoefW; k++) begin
      if (expo[k]) acc = mod_mul(acc, sq);
      sq = mod_mul(sq, sq);
    end
    return acc;
  endfunction

  // Factorials upward, then the inverse of the top factorial by Fermat, then downward.
  function automatic void rebuild_tables();
    fact_tab[0] = CoefW'(1);
    for (int i = 1; i < TableSize; i++) fact_tab[i] = mod_mul(fact_tab[i-1], CoefW'(i));
    inv_fact_tab[LastIdx] = mod_pow(fact_tab[LastIdx], InvExp);
    for (int i = LastIdx; i >= 3; i--) inv_fact_tab[i-1] = mod_mul(inv_fact_tab[i], CoefW'(i));
    inv_fact_tab[0] = CoefW'(1);
    inv_fact_tab[1] = CoefW'(1);
    tables_built = 1'b1;
  endfunction

  function automatic binom_rsp_t predict_coefficient(op_t op, logic [ArgW-1:0] n,
                                                    logic [ArgW-1:0] r);
    binom_rsp_t res;
    res.coefficient = '0;
    res.status      = ST_OK;
    if (op == OP_BUILD) begin
      rebuild_tables();
    end else if (!tables_built) begin
      res.status = ST_NOT_READY;
    end else if (r <= n && int'(n) < TableSize) begin
      res.coefficient = mod_mul(fact_tab[n], mod_mul(inv_fact_tab[r], inv_fact_tab[n - r]));
    end
    return res;
  endfunction

  always @(posedge clk) begin
    binom_rsp_t want;
    binom_rsp_t pred;
    if (rst) begin
      tables_built = 1'b0;
      expected_coef_q.delete();
      error_count = 0;
    end else begin
      if (req.valid && req.ready) begin
        pred = predict_coefficient(req.operation, req.total_count, req.choose_count);
        expected_coef_q.insert(expected_coef_q.size(), pred);
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_coef_q.size() == 0) begin
          error_count++;
          if (error_count <= ReportLimit) begin
            $display("%0t: response with no request waiting: coefficient %0d status %0d",
                     $realtime, rsp.coefficient, rsp.status);
          end
        end else begin
          want = expected_coef_q.pop_front();
          if (rsp.coefficient !== want.coefficient || rsp.status !== want.status) begin
            error_count++;
            if (error_count <= ReportLimit) begin
              $display("%0t: coefficient expected %0d got %0d, status expected %0d got %0d",
                       $realtime, want.coefficient, rsp.coefficient, want.status, rsp.status);
            end
          end
        end
      end
    end
    pending_count = expected_coef_q.size();
  end
endmodule

### dv/tb_top.sv
// Testbench top of the binomial coefficient table block: clock, reset, stimulus and verdict.
module tb_top import bmpt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomRequests = 1700;
  localparam int MaxN = (1 << ArgW) - 1;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  int   burst_left;

  bmpt_req_if req_ch();
  bmpt_rsp_if rsp_ch();

  binomial_mod_prime_tables i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  bmpt_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: ends the run as failed if it has not finished before this timeout.
  initial begin
    #4000000;
    $display("binomial_mod_prime_tables verification failed");
    $finish;
  end

  // The receiver follows a rotating stall pattern that is redrawn after each random-length run.
  initial begin
    logic [15:0] stall_pat;
    rsp_ch.ready = 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0:       stall_pat = '1;
        1:       stall_pat = 16'($urandom());
        default: stall_pat = 16'($urandom() & $urandom()) | (16'd1 << $urandom_range(0, 15));
      endcase
      repeat ($urandom_range(32, 400)) begin
        @(negedge clk);
        rsp_ch.ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  // Holds valid across a burst; a gap lowers it and drives junk on the payload meanwhile.
  task automatic send_request(input op_t op, input logic [ArgW-1:0] n, input logic [ArgW-1:0] r);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0: begin
          burst_left = $urandom_range(40, 80);
          gap = 0;
        end
        1, 2, 3: begin
          burst_left = $urandom_range(1, 12);
          gap = 0;
        end
        default: begin
          burst_left = $urandom_range(1, 12);
          gap = $urandom_range(1, 10);
        end
      endcase
      repeat (gap) begin
        req_ch.valid        <= 1'b0;
        req_ch.operation    <= op_t'($urandom_range(0, 1));
        req_ch.total_count  <= ArgW'($urandom());
        req_ch.choose_count <= ArgW'($urandom());
        @(negedge clk);
      end
    end
    burst_left--;
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.total_count  <= n;
    req_ch.choose_count <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pick_query(output logic [ArgW-1:0] n, output logic [ArgW-1:0] r);
    int nv;
    int rv;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
        nv = $urandom_range(0, MaxN);
        rv = $urandom_range(0, nv);
      end
      11, 12, 13: begin
        nv = $urandom_range(0, MaxN - 1);
        rv = $urandom_range(nv + 1, MaxN);
      end
      14, 15, 16: begin
        case ($urandom_range(0, 6))
          0:       nv = 0;
          1:       nv = 1;
          2:       nv = 2;
          3:       nv = MaxN;
          4:       nv = MaxN - 1;
          5:       nv = 2048;
          default: nv = $urandom_range(0, MaxN);
        endcase
        case ($urandom_range(0, 4))
          0:       rv = 0;
          1:       rv = 1;
          2:       rv = nv;
          3:       rv = (nv > 0) ? nv - 1 : 0;
          default: rv = nv / 2;
        endcase
      end
      default: begin
        nv = $urandom_range(0, MaxN);
        rv = $urandom_range(0, MaxN);
      end
    endcase
    n = ArgW'(nv);
    r = ArgW'(rv);
  endtask

  initial begin
    logic [ArgW-1:0] n;
    logic [ArgW-1:0] r;
    int builds_left;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.operation    = OP_BUILD;
    req_ch.total_count  = '0;
    req_ch.choose_count = '0;
    burst_left          = 0;
    builds_left         = 3;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Queries before any build must come back flagged as not ready.
    send_request(OP_QUERY, 12'd0, 12'd0);
    send_request(OP_QUERY, 12'hFFF, 12'hFFF);
    send_request(OP_QUERY, 12'd5, 12'd3);
    send_request(OP_QUERY, 12'd3, 12'd5);
    send_request(OP_BUILD, 12'hFFF, 12'hABC);
    send_request(OP_QUERY, 12'd0, 12'd0);
    send_request(OP_QUERY, 12'd1, 12'd0);
    send_request(OP_QUERY, 12'd1, 12'd1);
    send_request(OP_QUERY, 12'd2, 12'd1);
    send_request(OP_QUERY, 12'hFFF, 12'd0);
    send_request(OP_QUERY, 12'hFFF, 12'hFFF);
    send_request(OP_QUERY, 12'hFFF, 12'd1);
    send_request(OP_QUERY, 12'hFFF, 12'hFFE);
    send_request(OP_QUERY, 12'hFFF, 12'd2047);
    send_request(OP_QUERY, 12'hFFF, 12'd2048);
    send_request(OP_QUERY, 12'd2048, 12'd1024);
    send_request(OP_QUERY, 12'd100, 12'd50);
    send_request(OP_QUERY, 12'd0, 12'hFFF);
    send_request(OP_QUERY, 12'hFFE, 12'hFFF);
    send_request(OP_QUERY, 12'd10, 12'd11);
    // A second build must leave the tables as they were.
    send_request(OP_BUILD, 12'd0, 12'd0);
    send_request(OP_QUERY, 12'hFFF, 12'd2047);
    send_request(OP_QUERY, 12'd7, 12'd3);

    for (int i = 0; i < RandomRequests; i++) begin
      if (builds_left > 0 && $urandom_range(0, 499) == 0) begin
        builds_left--;
        send_request(OP_BUILD, ArgW'($urandom()), ArgW'($urandom()));
      end else begin
        pick_query(n, r);
        send_request(OP_QUERY, n, r);
      end
    end
    req_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("binomial_mod_prime_tables verification clean");
    end else begin
      $display("binomial_mod_prime_tables verification failed");
    end
    $finish;
  end
endmodule
